>>> rtl/sli_pkg.sv
// Package for the sorted list block: sizes, operation and status codes,
// request and response payload types. No dependencies.
package sli_pkg;

  localparam int CAPACITY = 16;
  localparam int OCCW     = $clog2(CAPACITY + 1);
  localparam int IDXW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int VALW     = 32;
  localparam int HELDW    = 5;
  localparam int QDEPTH   = 2;
  localparam int QPTRW    = 1;
  localparam int QCNTW    = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4,
    ST_READ_ITEM = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

  typedef struct packed {
    op_t                    operation;
    logic signed [VALW-1:0] value;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic signed [VALW-1:0] item_value;
    logic                   last;
    logic [HELDW-1:0]       entries_held;
  } rsp_t;

endpackage

>>> rtl/sli_front.sv
// Front end of the sorted list block: accepts request transfers into a
// two-entry command queue that the back end drains. Depends on sli_pkg.
module sli_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sli_pkg::req_t req,
  output logic          cmd_valid,
  input  logic          cmd_pop,
  output sli_pkg::req_t cmd
);
  import sli_pkg::*;

  req_t             slots [QDEPTH];
  logic [QPTRW-1:0] wr_ptr;
  logic [QPTRW-1:0] rd_ptr;
  logic [QCNTW-1:0] count;
  logic             push;
  logic             pop;

  assign req_stall = (count == QCNTW'(QDEPTH));
  assign push      = req_valid && !req_stall;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/sli_back.sv
// Back end of the sorted list block: row of value cells with parallel
// compare, insert/delete shift, read-out sequencer and response register.
// Depends on sli_pkg.
module sli_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  sli_pkg::req_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sli_pkg::rsp_t rsp
);
  import sli_pkg::*;

  logic signed [VALW-1:0] cells      [CAPACITY];
  logic signed [VALW-1:0] cells_next [CAPACITY];
  logic [OCCW-1:0]        occ;
  logic [OCCW-1:0]        occ_next;
  logic [IDXW-1:0]        idx;
  logic [IDXW-1:0]        idx_next;
  back_state_t            state;
  back_state_t            state_next;
  rsp_t                   rsp_next;
  logic                   emit;
  logic                   can_emit;
  logic                   ins_en;
  logic                   del_en;
  logic                   found;
  logic                   read_last;
  logic [CAPACITY-1:0]    at;    // insert: cell at or after slot
  logic [CAPACITY-1:0]    rm;    // delete: cell at or after match
  logic [CAPACITY-1:0]    eq;

  assign can_emit  = !rsp_valid || !rsp_stall;
  assign read_last = (idx == IDXW'(occ - 1'b1));

  // parallel compares against every cell
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      logic inval;
      inval = (OCCW'(i) < occ);
      at[i] = !inval || (cells[i] > cmd.value);
      rm[i] = inval && !(cells[i] < cmd.value);
      eq[i] = inval && (cells[i] == cmd.value);
    end
    found = |eq;
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_next[i] = cells[i];
      if (ins_en && at[i]) begin
        if (i == 0) begin
          cells_next[i] = cmd.value;
        end else if (at[i-1]) begin
          cells_next[i] = cells[i-1];
        end else begin
          cells_next[i] = cmd.value;
        end
      end else if (del_en && rm[i] && (i < CAPACITY - 1)) begin
        cells_next[i] = cells[i+1];
      end
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    occ_next   = occ;
    emit       = 1'b0;
    cmd_pop    = 1'b0;
    ins_en     = 1'b0;
    del_en     = 1'b0;
    rsp_next   = rsp;
    rsp_next.item_value = '0;
    rsp_next.last       = 1'b1;
    case (state)
      BK_IDLE: begin
        if (cmd_valid && can_emit) begin
          cmd_pop = 1'b1;
          emit    = 1'b1;
          case (cmd.operation)
            OP_INSERT: begin
              if (occ >= OCCW'(CAPACITY)) begin
                rsp_next.status = ST_FULL;
              end else begin
                ins_en          = 1'b1;
                occ_next        = occ + 1'b1;
                rsp_next.status = ST_INSERTED;
              end
            end
            OP_DELETE: begin
              if (found) begin
                del_en          = 1'b1;
                occ_next        = occ - 1'b1;
                rsp_next.status = ST_REMOVED;
              end else begin
                rsp_next.status = ST_NOT_FOUND;
              end
            end
            OP_CLEAR: begin
              occ_next        = '0;
              rsp_next.status = ST_CLEARED;
            end
            OP_READ: begin
              if (occ == '0) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                rsp_next.status     = ST_READ_ITEM;
                rsp_next.item_value = cells[0];
                rsp_next.last       = (occ == OCCW'(1));
                if (occ != OCCW'(1)) begin
                  state_next = BK_READ;
                  idx_next   = IDXW'(1);
                end
              end
            end
            default: rsp_next.status = ST_EMPTY;
          endcase
        end
      end
      BK_READ: begin
        if (can_emit) begin
          emit                = 1'b1;
          rsp_next.status     = ST_READ_ITEM;
          rsp_next.item_value = cells[idx];
          rsp_next.last       = read_last;
          if (read_last) begin
            state_next = BK_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
    rsp_next.entries_held = HELDW'(occ_next);
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
    idx   <= idx_next;
    if (emit) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/sorted_list_insert_delete.sv
// Sorted list, insert/delete/clear/read-out. A request passes through the
// command queue and then the response register. Insert, delete and clear
// each give one response from the back end; a read-out holds the back end
// until it has sent every entry held (or an empty status), one value per
// cycle unless stalled; the two-entry command queue takes requests meanwhile.
// Reset: occupancy zero, queue and response register empty; cells not cleared.
module sorted_list_insert_delete (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sli_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sli_pkg::rsp_t rsp
);
  import sli_pkg::*;

  // Command queue between front and back; each side stalls on its own.
  logic cmd_valid;
  logic cmd_pop;
  req_t cmd;

  // Front: takes request transfers while the queue has room.
  sli_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  // Back: compares all cells at once, shifts on insert/delete, and walks
  // the cells one per cycle for read-out while the response is not
  // stalled. Its response register decouples it from the consumer's stall.
  sli_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
